// ===== hw/rtl/fvcc_pkg.sv =====
// Shared types, constants and wheel tables for the flow vector colour coder.
package fvcc_pkg;

  localparam int WHEEL_ENTRIES = 55;
  localparam int PHASE_BITS    = 20;
  localparam int CORDIC_STEPS  = 18;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = 15;

  // register stages of each unit
  localparam int CORDIC_LAT  = CORDIC_STEPS + 1;
  localparam int WHEEL_LAT   = 4;
  localparam int MAG_LAT     = 2 + SQRT_STEPS + 1 + DIV_STEPS;
  localparam int COLOR_DELAY = MAG_LAT - CORDIC_LAT - WHEEL_LAT;

  localparam logic [15:0] ONE_Q15      = 16'd32768;
  localparam logic [22:0] MAX_FLOW_RST = 23'd2560;

  typedef struct packed {
    logic signed [23:0] flow_u;
    logic signed [23:0] flow_v;
  } in_item_t;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } out_item_t;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } rgb_t;

  // atan(2^-i) in units of 2^-20 turn
  localparam logic signed [21:0] ATAN_TURNS [CORDIC_STEPS] = '{
    22'sd131072, 22'sd77376, 22'sd40884, 22'sd20753, 22'sd10417, 22'sd5213,
    22'sd2607, 22'sd1304, 22'sd652, 22'sd326, 22'sd163, 22'sd81,
    22'sd41, 22'sd20, 22'sd10, 22'sd5, 22'sd3, 22'sd1
  };

  // k/n in Q1.15, rounded half up, for each segment length
  localparam logic [15:0] F15 [15] = '{
    16'd0, 16'd2185, 16'd4369, 16'd6554, 16'd8738, 16'd10923, 16'd13107,
    16'd15292, 16'd17476, 16'd19661, 16'd21845, 16'd24030, 16'd26214,
    16'd28399, 16'd30583
  };
  localparam logic [15:0] F6 [6] = '{
    16'd0, 16'd5461, 16'd10923, 16'd16384, 16'd21845, 16'd27307
  };
  localparam logic [15:0] F4 [4] = '{16'd0, 16'd8192, 16'd16384, 16'd24576};
  localparam logic [15:0] F11 [11] = '{
    16'd0, 16'd2979, 16'd5958, 16'd8937, 16'd11916, 16'd14895, 16'd17873,
    16'd20852, 16'd23831, 16'd26810, 16'd29789
  };
  localparam logic [15:0] F13 [13] = '{
    16'd0, 16'd2521, 16'd5041, 16'd7562, 16'd10082, 16'd12603, 16'd15124,
    16'd17644, 16'd20165, 16'd22686, 16'd25206, 16'd27727, 16'd30247
  };

  function automatic rgb_t wheel_rgb(input logic [5:0] idx);
    rgb_t c;
    c = '0;
    if (idx < 6'd15) begin
      c.r = ONE_Q15;
      c.g = F15[idx[3:0]];
    end else if (idx < 6'd21) begin
      c.r = ONE_Q15 - F6[3'(idx - 6'd15)];
      c.g = ONE_Q15;
    end else if (idx < 6'd25) begin
      c.g = ONE_Q15;
      c.b = F4[2'(idx - 6'd21)];
    end else if (idx < 6'd36) begin
      c.g = ONE_Q15 - F11[4'(idx - 6'd25)];
      c.b = ONE_Q15;
    end else if (idx < 6'd49) begin
      c.r = F13[4'(idx - 6'd36)];
      c.b = ONE_Q15;
    end else begin
      c.r = ONE_Q15;
      c.b = ONE_Q15 - F6[3'(idx - 6'd49)];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fvcc_cordic.sv =====
// Pipelined CORDIC vectoring unit: flow vector to phase in turns.
module fvcc_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [23:0] in_u,
  input  logic signed [23:0] in_v,
  output logic               out_vld,
  output logic [19:0]        out_phase
);

  localparam int N = fvcc_pkg::CORDIC_STEPS;

  logic signed [35:0] x_r [N+1];
  logic signed [35:0] y_r [N+1];
  logic signed [21:0] z_r [N+1];
  logic               zero_r [N+1];
  logic               vld_r [N+1];

  logic signed [35:0] u_ext, v_ext, x_nxt, y_nxt;
  logic signed [21:0] z_nxt;

  always_comb begin
    u_ext = 36'(in_u);
    v_ext = 36'(in_v);
    if (in_u < 0) begin
      // fold into the right half-plane and add half a turn
      x_nxt = (-u_ext) <<< 8;
      y_nxt = (-v_ext) <<< 8;
      z_nxt = 22'sd524288;
    end else begin
      x_nxt = u_ext <<< 8;
      y_nxt = v_ext <<< 8;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= x_nxt;
    y_r[0]    <= y_nxt;
    z_r[0]    <= z_nxt;
    zero_r[0] <= (in_u == 24'sd0) && (in_v == 24'sd0);
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      zero_r[k+1] <= zero_r[k];
      if (y_r[k] > 0) begin
        x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] + fvcc_pkg::ATAN_TURNS[k];
      end else begin
        x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] - fvcc_pkg::ATAN_TURNS[k];
      end
    end
  end

  assign out_vld   = vld_r[N];
  assign out_phase = zero_r[N] ? '0 : z_r[N][19:0];

endmodule

// ===== hw/rtl/fvcc_wheel.sv =====
// Colour wheel lookup and linear interpolation between neighbouring entries.
module fvcc_wheel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [19:0]          in_phase,
  output logic                 out_vld,
  output fvcc_pkg::rgb_t       out_color
);

  logic [3:0]  vld_r;
  logic [5:0]  idx_r, nidx_r;
  logic [19:0] w1_r, w2_r;
  fvcc_pkg::rgb_t c1_r, c2_r;
  logic [36:0] pa_r [3];
  logic [36:0] pb_r [3];
  fvcc_pkg::rgb_t color_r;

  logic [25:0] pos;
  logic [20:0] wc;
  logic [37:0] sum [3];
  logic [15:0] a_ch [3];
  logic [15:0] b_ch [3];

  assign pos = 26'(in_phase) * 26'(fvcc_pkg::WHEEL_ENTRIES);
  assign wc  = 21'(1 << fvcc_pkg::PHASE_BITS) - 21'(w2_r);

  always_comb begin
    a_ch[0] = c1_r.r;  b_ch[0] = c2_r.r;
    a_ch[1] = c1_r.g;  b_ch[1] = c2_r.g;
    a_ch[2] = c1_r.b;  b_ch[2] = c2_r.b;
    for (int i = 0; i < 3; i++) begin
      sum[i] = 38'(pa_r[i]) + 38'(pb_r[i]) + 38'(1 << (fvcc_pkg::PHASE_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= pos[25:20];
    nidx_r <= (pos[25:20] == 6'(fvcc_pkg::WHEEL_ENTRIES - 1)) ? 6'd0 : pos[25:20] + 6'd1;
    w1_r   <= pos[19:0];
    c1_r   <= fvcc_pkg::wheel_rgb(idx_r);
    c2_r   <= fvcc_pkg::wheel_rgb(nidx_r);
    w2_r   <= w1_r;
    for (int i = 0; i < 3; i++) begin
      pa_r[i] <= 37'(a_ch[i]) * 37'(wc);
      pb_r[i] <= 37'(b_ch[i]) * 37'(w2_r);
    end
    color_r.r <= sum[0][35:20];
    color_r.g <= sum[1][35:20];
    color_r.b <= sum[2][35:20];
  end

  assign out_vld   = vld_r[3];
  assign out_color = color_r;

endmodule

// ===== hw/rtl/fvcc_mag.sv =====
// Saturation path: squared length, pipelined square root and divide by max flow.
module fvcc_mag (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [23:0] in_u,
  input  logic signed [23:0] in_v,
  input  logic [22:0]        max_flow,
  output logic               out_vld,
  output logic [15:0]        out_sat
);

  localparam int NS = fvcc_pkg::SQRT_STEPS;
  localparam int ND = fvcc_pkg::DIV_STEPS;

  logic signed [47:0] usq, vsq;
  logic [46:0] usq_r, vsq_r;
  logic [1:0]  pre_vld_r;

  logic [63:0] n_r   [NS+1];
  logic [63:0] res_r [NS+1];
  logic        s_vld_r [NS+1];

  logic [22:0] rem_r  [ND+1];
  logic [14:0] bits_r [ND+1];
  logic [14:0] q_r    [ND+1];
  logic        sat_r  [ND+1];
  logic        d_vld_r [ND+1];

  logic [22:0] mf;
  logic [31:0] rad;

  assign usq = in_u * in_u;
  assign vsq = in_v * in_v;
  assign mf  = (max_flow == '0) ? 23'd1 : max_flow;
  assign rad = res_r[NS][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= '0;
    end else begin
      pre_vld_r <= {pre_vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    usq_r    <= usq[46:0];
    vsq_r    <= vsq[46:0];
    n_r[0]   <= {48'(usq_r) + 48'(vsq_r), 16'd0};
    res_r[0] <= '0;
  end

  assign s_vld_r[0] = pre_vld_r[1];

  // one result bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] t;
    assign t = res_r[j] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[j+1] <= 1'b0;
      end else begin
        s_vld_r[j+1] <= s_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (n_r[j] >= t) begin
        n_r[j+1]   <= n_r[j] - t;
        res_r[j+1] <= (res_r[j] >> 1) + BIT;
      end else begin
        n_r[j+1]   <= n_r[j];
        res_r[j+1] <= res_r[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r[0] <= 1'b0;
    end else begin
      d_vld_r[0] <= s_vld_r[NS];
    end
  end

  // saturate when rad * 2^7 reaches max_flow * 2^15
  always_ff @(posedge clk) begin
    sat_r[0]  <= rad >= {1'b0, mf, 8'd0};
    rem_r[0]  <= rad[30:8];
    bits_r[0] <= {rad[7:0], 7'd0};
    q_r[0]    <= '0;
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [23:0] rem2;
    assign rem2 = {rem_r[k], bits_r[k][14]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[k+1] <= 1'b0;
      end else begin
        d_vld_r[k+1] <= d_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sat_r[k+1]  <= sat_r[k];
      bits_r[k+1] <= bits_r[k] << 1;
      if (rem2 >= {1'b0, mf}) begin
        rem_r[k+1] <= 23'(rem2 - {1'b0, mf});
        q_r[k+1]   <= {q_r[k][13:0], 1'b1};
      end else begin
        rem_r[k+1] <= rem2[22:0];
        q_r[k+1]   <= {q_r[k][13:0], 1'b0};
      end
    end
  end

  assign out_vld = d_vld_r[ND];
  assign out_sat = sat_r[ND] ? fvcc_pkg::ONE_Q15 : {1'b0, q_r[ND]};

endmodule

// ===== hw/rtl/flow_vector_color_coder.sv =====
// Top level of the flow vector colour coder: input stage, units, delay and blend.
//
//  channel | ports                        | handshake
//  --------+------------------------------+-------------------------------
//  input   | start, busy, in_data         | taken when start && !busy
//  result  | out_strobe, out_data         | one cycle per item, no stall
//  config  | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// One item per clock; busy is never raised and cfg_ready is always high.
// The result timing is set by the 32-stage square root and 15-stage divider
// of the saturation path; the hue path is delayed to meet it. Synchronous reset
// clears valid bits and loads max_flow = 2560.
// The receiver cannot stall, so the pipeline never holds.
module flow_vector_color_coder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fvcc_pkg::in_item_t   in_data,
  output logic                 out_strobe,
  output fvcc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [22:0]          cfg_data
);

  localparam int D = fvcc_pkg::COLOR_DELAY;

  logic                in_vld_r;
  fvcc_pkg::in_item_t  in_data_r;
  logic [22:0]         max_flow_r;

  logic                col_vld, mag_vld;
  logic [19:0]         phase;
  logic                cor_vld;
  fvcc_pkg::rgb_t      color;
  logic [15:0]         sat;

  fvcc_pkg::rgb_t      dly_r [D];
  logic                dly_vld_r [D];

  logic                b1_vld_r;
  logic [31:0]         prod_r [3];
  logic                out_vld_r;
  fvcc_pkg::out_item_t out_data_r;

  logic [15:0]         ch [3];
  logic [32:0]         rnd [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      max_flow_r <= fvcc_pkg::MAX_FLOW_RST;
    end else begin
      in_vld_r <= start && !busy;
      if (cfg_valid && cfg_ready) begin
        max_flow_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_data_r <= in_data;
  end

  fvcc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld_r),
    .in_u      (in_data_r.flow_u),
    .in_v      (in_data_r.flow_v),
    .out_vld   (cor_vld),
    .out_phase (phase)
  );

  fvcc_wheel u_wheel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (cor_vld),
    .in_phase  (phase),
    .out_vld   (col_vld),
    .out_color (color)
  );

  fvcc_mag u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_u     (in_data_r.flow_u),
    .in_v     (in_data_r.flow_v),
    .max_flow (max_flow_r),
    .out_vld  (mag_vld),
    .out_sat  (sat)
  );

  // hold the wheel colour until the saturation arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D; k++) dly_vld_r[k] <= 1'b0;
    end else begin
      dly_vld_r[0] <= col_vld;
      for (int k = 1; k < D; k++) dly_vld_r[k] <= dly_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= color;
    for (int k = 1; k < D; k++) dly_r[k] <= dly_r[k-1];
  end

  always_comb begin
    ch[0] = dly_r[D-1].b;
    ch[1] = dly_r[D-1].g;
    ch[2] = dly_r[D-1].r;
    for (int i = 0; i < 3; i++) begin
      rnd[i] = {1'b0, prod_r[i]} + 33'd16384;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      b1_vld_r  <= mag_vld && dly_vld_r[D-1];
      out_vld_r <= b1_vld_r;
    end
  end

  // blend each channel toward white by the saturation
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= 32'(fvcc_pkg::ONE_Q15 - ch[i]) * 32'(sat);
    end
    out_data_r.blue  <= 16'(18'd32768 - rnd[0][32:15]);
    out_data_r.green <= 16'(18'd32768 - rnd[1][32:15]);
    out_data_r.red   <= 16'(18'd32768 - rnd[2][32:15]);
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_data_r;

endmodule

// ===== tb/flow_vector_color_coder_tb.sv =====
// Self-checking testbench for the flow vector colour coder: predicted colours vs. DUT output.
module flow_vector_color_coder_tb;

  localparam int  PIPE_WAIT   = 60;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  FRAC        = 20;
  localparam longint unsigned PHASE_MASK = (64'd1 << FRAC) - 1;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  fvcc_pkg::in_item_t  in_data;
  logic                out_strobe;
  fvcc_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [22:0]         cfg_data;

  fvcc_pkg::in_item_t  vectors_pending[$];
  fvcc_pkg::out_item_t colours_due[$];
  logic [22:0]         max_flow_shadow;
  logic                took;
  int                  idle_pct;
  int                  errors;
  int                  cycles;

  flow_vector_color_coder uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // atan(2^-i) in 2^-20 turn units
  localparam longint ARC_STEP [18] = '{
    131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304, 652,
    326, 163, 81, 41, 20, 10, 5, 3, 1
  };

  function automatic longint unsigned seg_frac(int k, int n);
    return (64'd32768 * k + n / 2) / n;
  endfunction

  // wheel colour as {r, g, b}
  function automatic void hue_colour(input int idx, output longint unsigned r,
                                     output longint unsigned g, output longint unsigned b);
    r = 0; g = 0; b = 0;
    if (idx < 15) begin
      r = 32768; g = seg_frac(idx, 15);
    end else if (idx < 21) begin
      r = 32768 - seg_frac(idx - 15, 6); g = 32768;
    end else if (idx < 25) begin
      g = 32768; b = seg_frac(idx - 21, 4);
    end else if (idx < 36) begin
      g = 32768 - seg_frac(idx - 25, 11); b = 32768;
    end else if (idx < 49) begin
      r = seg_frac(idx - 36, 13); b = 32768;
    end else begin
      r = 32768; b = 32768 - seg_frac((idx - 49) % 6, 6);
    end
  endfunction

  function automatic longint unsigned flow_phase(longint u, longint v);
    longint x, y, z, xs, ys;
    x = u; y = v; z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd1 <<< (FRAC - 1);
    end
    x = x * 256; y = y * 256;
    for (int i = 0; i < 18; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ARC_STEP[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ARC_STEP[i];
      end
    end
    return longint'(z) & PHASE_MASK;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0; bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv); res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned w, longint unsigned s);
    longint unsigned c;
    c = (a * ((64'd1 << FRAC) - w) + b * w + (64'd1 << (FRAC - 1))) >> FRAC;
    return 32768 - (((32768 - c) * s + 16384) >> 15);
  endfunction

  function automatic fvcc_pkg::out_item_t colour_of(fvcc_pkg::in_item_t item,
                                                     logic [22:0] mflow);
    longint u, v;
    longint unsigned pos, w, rad, mf, q, s, r1, g1, b1, r2, g2, b2;
    int i1, i2;
    fvcc_pkg::out_item_t o;
    u = item.flow_u; v = item.flow_v;
    pos = flow_phase(u, v) * 55;
    i1 = int'((pos >> FRAC) % 55);
    i2 = (i1 + 1) % 55;
    w = pos & PHASE_MASK;
    hue_colour(i1, r1, g1, b1);
    hue_colour(i2, r2, g2, b2);
    rad = root_floor((longint'(u * u) + longint'(v * v)) << 16);
    mf = (mflow == 0) ? 1 : mflow;
    q = (rad << 15) / (mf << 8);
    s = (q > 32768) ? 32768 : q;
    o.blue  = 16'(blend(b1, b2, w, s));
    o.green = 16'(blend(g1, g2, w, s));
    o.red   = 16'(blend(r1, r2, w, s));
    return o;
  endfunction

  function automatic fvcc_pkg::in_item_t vec(int u, int v);
    fvcc_pkg::in_item_t it;
    it.flow_u = 24'(u);
    it.flow_v = 24'(v);
    return it;
  endfunction

  function automatic fvcc_pkg::in_item_t random_vec(logic [22:0] mflow);
    fvcc_pkg::in_item_t it;
    int span;
    case ($urandom_range(3))
      0: begin
        it.flow_u = 24'($urandom); it.flow_v = 24'($urandom);
      end
      1: begin
        // around the saturation knee
        span = (mflow > 23'd4000000) ? 4000000 : int'(mflow) + 2;
        it.flow_u = 24'($signed($urandom_range(2 * span)) - span);
        it.flow_v = 24'($signed($urandom_range(2 * span)) - span);
      end
      2: begin
        it.flow_u = 24'($signed($urandom_range(64)) - 32);
        it.flow_v = 24'($signed($urandom_range(64)) - 32);
      end
      default: begin
        // near an axis
        it.flow_u = 24'($urandom);
        it.flow_v = 24'($signed($urandom_range(6)) - 3);
        if ($urandom_range(1)) it = vec(it.flow_v, it.flow_u);
      end
    endcase
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // predict on acceptance, track the register
  always @(posedge clk) begin
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy)
      colours_due.push_back(colour_of(in_data, max_flow_shadow));
    if (!rst_n)
      max_flow_shadow <= fvcc_pkg::MAX_FLOW_RST;
    else if (cfg_valid && cfg_ready)
      max_flow_shadow <= cfg_data;
  end

  always @(posedge clk) begin
    fvcc_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (colours_due.size() == 0) begin
        $display("%0t: unexpected colour %0d/%0d/%0d", $time,
                 out_data.blue, out_data.green, out_data.red);
        errors++;
      end else begin
        want = colours_due.pop_front();
        if (out_data.blue !== want.blue) begin
          $display("%0t: blue exp %0d got %0d", $time, want.blue, out_data.blue);
          errors++;
        end
        if (out_data.green !== want.green) begin
          $display("%0t: green exp %0d got %0d", $time, want.green, out_data.green);
          errors++;
        end
        if (out_data.red !== want.red) begin
          $display("%0t: red exp %0d got %0d", $time, want.red, out_data.red);
          errors++;
        end
      end
    end
  end

  // drop the item taken at the last edge, then offer the next one
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) vectors_pending.pop_front();
      if (vectors_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        in_data <= vectors_pending[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic drain();
    wait (vectors_pending.size() == 0 && !start && colours_due.size() == 0);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_max_flow(logic [22:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      vectors_pending.push_back(random_vec(max_flow_shadow));
  endtask

  initial begin
    logic [22:0] settings [5];
    errors = 0; cycles = 0; idle_pct = 20; took = 1'b0;
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero vector, extremes, axes, full-turn neighbourhood
    vectors_pending.push_back(vec(0, 0));
    vectors_pending.push_back(vec(8388607, 0));
    vectors_pending.push_back(vec(-8388608, 0));
    vectors_pending.push_back(vec(0, 8388607));
    vectors_pending.push_back(vec(0, -8388608));
    vectors_pending.push_back(vec(-8388608, -8388608));
    vectors_pending.push_back(vec(8388607, 8388607));
    vectors_pending.push_back(vec(-8388608, 8388607));
    vectors_pending.push_back(vec(8388607, -8388608));
    vectors_pending.push_back(vec(1, 0));
    vectors_pending.push_back(vec(-1, 0));
    vectors_pending.push_back(vec(0, 1));
    vectors_pending.push_back(vec(0, -1));
    vectors_pending.push_back(vec(1, -1));
    vectors_pending.push_back(vec(-1, 1));
    vectors_pending.push_back(vec(1000000, -1));
    vectors_pending.push_back(vec(-1000000, 1));
    vectors_pending.push_back(vec(-1000000, -1));
    vectors_pending.push_back(vec(2560, 0));
    vectors_pending.push_back(vec(1810, 1810));
    vectors_pending.push_back(vec(1280, -1280));
    queue_random(330);
    drain();

    settings = '{23'd1, 23'd8388607, 23'd0, 23'd300, 23'($urandom_range(1, 8388607))};
    foreach (settings[k]) begin
      write_max_flow(settings[k]);
      idle_pct = (k == 1) ? 0 : 20;
      queue_random(150);
      // hold the sender until every colour is back
      if (k == 2) drain();
      queue_random(150);
      drain();
    end

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== flow_vector_color_coder.f =====
hw/rtl/fvcc_pkg.sv
hw/rtl/fvcc_cordic.sv
hw/rtl/fvcc_wheel.sv
hw/rtl/fvcc_mag.sv
hw/rtl/flow_vector_color_coder.sv
tb/flow_vector_color_coder_tb.sv
